[sv/tta_pkg.sv]
package tta_pkg;

  localparam int TEMP_BITS_DEF = 16;
  localparam int TICK_BITS     = 16;
  localparam int KIND_BITS     = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int TRIP_EN_BITS  = 3;

  localparam logic [TICK_BITS-1:0] WDT_TICKS_RESET = 16'd15;

  // input item kinds
  localparam logic [KIND_BITS-1:0] KIND_REPORT    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_EMERG_ON  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_EMERG_OFF = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_RESUME    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_TICK      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WARM_TRIP = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HOT_TRIP  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CRIT_TRIP = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TRIP_EN   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WDT_TICKS = 3'd4;

  // crossed level codes
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_WARM = 2'd1;
  localparam logic [1:0] LEVEL_HOT  = 2'd2;
  localparam logic [1:0] LEVEL_CRIT = 2'd3;

  // power request codes
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_SLEEP     = 2'd1;
  localparam logic [1:0] ACT_HIBERNATE = 2'd2;
  localparam logic [1:0] ACT_SHUTDOWN  = 2'd3;

endpackage

[sv/tta_eval.sv]
module tta_eval
  import tta_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF
) (
  input  logic [TEMP_BITS-1:0]    temp,
  input  logic [TEMP_BITS-1:0]    warm_trip,
  input  logic [TEMP_BITS-1:0]    hot_trip,
  input  logic [TEMP_BITS-1:0]    crit_trip,
  input  logic [TRIP_EN_BITS-1:0] trip_en,
  output logic [TEMP_BITS-1:0]    lower,
  output logic                    lower_valid,
  output logic [TEMP_BITS-1:0]    upper,
  output logic                    upper_valid,
  output logic [1:0]              level,
  output logic [TEMP_BITS-1:0]    crossed_val
);

  logic [TEMP_BITS-1:0] trip [TRIP_EN_BITS];

  assign trip[0] = warm_trip;
  assign trip[1] = hot_trip;
  assign trip[2] = crit_trip;

  // later trips are more severe, so they win on equal values
  always_comb begin
    lower       = '0;
    lower_valid = 1'b0;
    upper       = '0;
    upper_valid = 1'b0;
    level       = LEVEL_NONE;
    crossed_val = '0;
    for (int i = 0; i < TRIP_EN_BITS; i++) begin
      if (trip_en[i]) begin
        if (temp >= trip[i]) begin
          if (!lower_valid || trip[i] > lower) begin
            lower       = trip[i];
            lower_valid = 1'b1;
          end
          level       = 2'(i + 1);
          crossed_val = trip[i];
        end else begin
          if (!upper_valid || trip[i] < upper) begin
            upper       = trip[i];
            upper_valid = 1'b1;
          end
        end
      end
    end
  end

endmodule

[sv/tta_cfg.sv]
module tta_cfg
  import tta_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int CFG_W     = (TEMP_BITS > TICK_BITS) ? TEMP_BITS : TICK_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic [TEMP_BITS-1:0]     warm_trip,
  output logic [TEMP_BITS-1:0]     hot_trip,
  output logic [TEMP_BITS-1:0]     crit_trip,
  output logic [TRIP_EN_BITS-1:0]  trip_en,
  output logic [TICK_BITS-1:0]     wdt_ticks
);

  logic [TEMP_BITS-1:0]    warm_trip_r;
  logic [TEMP_BITS-1:0]    hot_trip_r;
  logic [TEMP_BITS-1:0]    crit_trip_r;
  logic [TRIP_EN_BITS-1:0] trip_en_r;
  logic [TICK_BITS-1:0]    wdt_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_trip_r <= '0;
      hot_trip_r  <= '0;
      crit_trip_r <= '0;
      trip_en_r   <= '0;
      wdt_ticks_r <= WDT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WARM_TRIP: warm_trip_r <= cfg_wdata[TEMP_BITS-1:0];
        CFG_HOT_TRIP:  hot_trip_r  <= cfg_wdata[TEMP_BITS-1:0];
        CFG_CRIT_TRIP: crit_trip_r <= cfg_wdata[TEMP_BITS-1:0];
        CFG_TRIP_EN:   trip_en_r   <= cfg_wdata[TRIP_EN_BITS-1:0];
        CFG_WDT_TICKS: wdt_ticks_r <= cfg_wdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign warm_trip = warm_trip_r;
  assign hot_trip  = hot_trip_r;
  assign crit_trip = crit_trip_r;
  assign trip_en   = trip_en_r;
  assign wdt_ticks = wdt_ticks_r;

endmodule

[sv/tta_ctrl.sv]
module tta_ctrl
  import tta_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int RES_W     = 3 * TEMP_BITS + 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [KIND_BITS-1:0]    kind,
  input  logic [TEMP_BITS-1:0]    temp,
  input  logic [TEMP_BITS-1:0]    warm_trip,
  input  logic [TEMP_BITS-1:0]    hot_trip,
  input  logic [TEMP_BITS-1:0]    crit_trip,
  input  logic [TRIP_EN_BITS-1:0] trip_en,
  input  logic [TICK_BITS-1:0]    wdt_ticks,
  output logic [RES_W-1:0]        res
);

  logic [TEMP_BITS-1:0] last_temp_r, last_temp_nxt;
  logic                 known_r, known_nxt;
  logic                 sleep_r, sleep_nxt;
  logic                 hib_r, hib_nxt;
  logic                 emerg_r, emerg_nxt;
  logic                 wdt_run_r, wdt_run_nxt;
  logic [TICK_BITS-1:0] wdt_cnt_r, wdt_cnt_nxt;

  logic [TEMP_BITS-1:0] eval_temp;
  logic [TEMP_BITS-1:0] lower, upper, crossed_val;
  logic                 lower_valid, upper_valid;
  logic [1:0]           level;
  logic [TICK_BITS-1:0] cnt_dec;
  logic                 expire;
  logic                 do_eval;
  logic                 emerg_eff, sleep_eff, hib_eff;
  logic [1:0]           action;

  assign eval_temp = (kind == KIND_REPORT) ? temp : last_temp_r;

  tta_eval #(.TEMP_BITS(TEMP_BITS)) u_eval (
    .temp        (eval_temp),
    .warm_trip   (warm_trip),
    .hot_trip    (hot_trip),
    .crit_trip   (crit_trip),
    .trip_en     (trip_en),
    .lower       (lower),
    .lower_valid (lower_valid),
    .upper       (upper),
    .upper_valid (upper_valid),
    .level       (level),
    .crossed_val (crossed_val)
  );

  assign cnt_dec = (wdt_cnt_r != '0) ? wdt_cnt_r - 1'b1 : wdt_cnt_r;
  assign expire  = (kind == KIND_TICK) && wdt_run_r && (cnt_dec == '0);

  // emergency off and watchdog expiry take effect before the re-evaluation
  assign emerg_eff = (kind == KIND_EMERG_OFF) ? 1'b0 : emerg_r;
  assign sleep_eff = expire ? 1'b0 : sleep_r;
  assign hib_eff   = expire ? 1'b0 : hib_r;

  always_comb begin
    last_temp_nxt = last_temp_r;
    known_nxt     = known_r;
    sleep_nxt     = sleep_r;
    hib_nxt       = hib_r;
    emerg_nxt     = emerg_r;
    wdt_run_nxt   = wdt_run_r;
    wdt_cnt_nxt   = wdt_cnt_r;
    do_eval       = 1'b0;
    action        = ACT_NONE;

    case (kind)
      KIND_REPORT: begin
        last_temp_nxt = temp;
        known_nxt     = 1'b1;
        do_eval       = 1'b1;
      end
      KIND_EMERG_ON: emerg_nxt = 1'b1;
      KIND_EMERG_OFF: begin
        if (emerg_r) begin
          emerg_nxt = 1'b0;
          do_eval   = known_r;
        end
      end
      KIND_RESUME: begin
        sleep_nxt   = 1'b0;
        hib_nxt     = 1'b0;
        wdt_run_nxt = 1'b0;
        wdt_cnt_nxt = '0;
      end
      KIND_TICK: begin
        if (wdt_run_r) begin
          wdt_cnt_nxt = cnt_dec;
          if (expire) begin
            wdt_run_nxt = 1'b0;
            sleep_nxt   = 1'b0;
            hib_nxt     = 1'b0;
            do_eval     = known_r;
          end
        end
      end
      default: ;
    endcase

    if (do_eval && !emerg_eff) begin
      case (level)
        LEVEL_WARM: begin
          if (!sleep_eff) begin
            sleep_nxt = 1'b1;
            action    = ACT_SLEEP;
          end
        end
        LEVEL_HOT: begin
          if (!hib_eff) begin
            hib_nxt = 1'b1;
            action  = ACT_HIBERNATE;
          end
        end
        LEVEL_CRIT: action = ACT_SHUTDOWN;
        default: ;
      endcase
      if (action != ACT_NONE) begin
        wdt_run_nxt = 1'b1;
        wdt_cnt_nxt = (wdt_ticks == '0) ? TICK_BITS'(1) : wdt_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r <= '0;
      known_r     <= 1'b0;
      sleep_r     <= 1'b0;
      hib_r       <= 1'b0;
      emerg_r     <= 1'b0;
      wdt_run_r   <= 1'b0;
      wdt_cnt_r   <= '0;
    end else if (go) begin
      last_temp_r <= last_temp_nxt;
      known_r     <= known_nxt;
      sleep_r     <= sleep_nxt;
      hib_r       <= hib_nxt;
      emerg_r     <= emerg_nxt;
      wdt_run_r   <= wdt_run_nxt;
      wdt_cnt_r   <= wdt_cnt_nxt;
    end
  end

  // all fields read zero on an item that does not evaluate
  assign res = do_eval ? {crossed_val, action, level, upper_valid, upper,
                          lower_valid, lower, 1'b1}
                       : '0;

endmodule

[sv/thermal_trip_power_action.sv]
// Path: a beat accepted on the input loads the input register, then the result
//   register, which drives out_tvalid; that load waits while out_tready holds it.
// Throughput: one beat per cycle; in_tready drops only while the result
//   register is held by out_tready low and the input register is full.
// Reset: synchronous, active-low rst_n clears both valid flags, the policy
//   state and the trip configuration (watchdog ticks reset to 15).
module thermal_trip_power_action
  import tta_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int CFG_W     = (TEMP_BITS > TICK_BITS) ? TEMP_BITS : TICK_BITS,
  parameter int IN_W      = ((TEMP_BITS + 7) / 8) * 8,
  parameter int RES_W     = 3 * TEMP_BITS + 7,
  parameter int OUT_W     = ((RES_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,   // temperature
  input  logic [KIND_BITS-1:0]     in_tuser,   // kind
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // evaluated, lower_threshold, lower_valid, upper_threshold, upper_valid,
  // crossed_level, action, crossed_trip_value
  output logic [OUT_W-1:0]         out_tdata
);

  logic [TEMP_BITS-1:0]    warm_trip, hot_trip, crit_trip;
  logic [TRIP_EN_BITS-1:0] trip_en;
  logic [TICK_BITS-1:0]    wdt_ticks;

  logic                 in_v_r;
  logic [KIND_BITS-1:0] kind_r;
  logic [TEMP_BITS-1:0] temp_r;
  logic                 out_v_r;
  logic [RES_W-1:0]     res_r;
  logic [RES_W-1:0]     res;
  logic                 advance;
  logic                 go;

  tta_cfg #(.TEMP_BITS(TEMP_BITS), .CFG_W(CFG_W)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .warm_trip (warm_trip),
    .hot_trip  (hot_trip),
    .crit_trip (crit_trip),
    .trip_en   (trip_en),
    .wdt_ticks (wdt_ticks)
  );

  assign advance   = !out_v_r || out_tready;
  assign go        = in_v_r && advance;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      temp_r <= in_tdata[TEMP_BITS-1:0];
    end
  end

  tta_ctrl #(.TEMP_BITS(TEMP_BITS), .RES_W(RES_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .kind      (kind_r),
    .temp      (temp_r),
    .warm_trip (warm_trip),
    .hot_trip  (hot_trip),
    .crit_trip (crit_trip),
    .trip_en   (trip_en),
    .wdt_ticks (wdt_ticks),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(res_r);

endmodule

[sv/tta_checker.sv]
module tta_checker
  import tta_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int OUT_W     = ((3 * TEMP_BITS + 7 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int LV_POS  = TEMP_BITS + 1;
  localparam int UV_POS  = 2 * TEMP_BITS + 2;
  localparam int LVL_LO  = 2 * TEMP_BITS + 3;
  localparam int ACT_LO  = 2 * TEMP_BITS + 5;

  logic       evaluated;
  logic       lower_valid;
  logic       upper_valid;
  logic [1:0] level;
  logic [1:0] action;

  assign evaluated   = out_tdata[0];
  assign lower_valid = out_tdata[LV_POS];
  assign upper_valid = out_tdata[UV_POS];
  assign level       = out_tdata[LVL_LO+1:LVL_LO];
  assign action      = out_tdata[ACT_LO+1:ACT_LO];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !evaluated |-> out_tdata == '0)
    else $error("non-evaluating beat carries data");

  a_action_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && action != ACT_NONE |-> action == level)
    else $error("power request does not match crossed level");

  a_lower_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && evaluated |-> lower_valid == (level != LEVEL_NONE))
    else $error("lower threshold and crossed level disagree");

  a_valid_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && level == LEVEL_CRIT |-> !upper_valid || evaluated)
    else $error("critical level without evaluation");

endmodule

bind thermal_trip_power_action tta_checker #(
  .TEMP_BITS (TEMP_BITS),
  .OUT_W     (OUT_W)
) u_tta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
